FILE: rtl/core/chpq_pkg.sv
// Shared types, codes and constants of the canonical Huffman pair/quad decoder.
// Used by the controller, the datapath and the top level; depends on nothing.

package chpq_pkg;

  // Defaults for the top level parameters
  localparam int MAX_CODE_LEN_DEF  = 19;
  localparam int TABLE_ENTRIES_DEF = 256;

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int LSEL_W    = 5;
  localparam int CNT_W     = 9;
  localparam int FIRST_W   = 8;
  localparam int ENTRY_W   = 8;
  localparam int CODE_W    = 19;
  localparam int SYM_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int NIB_W     = 4;
  localparam int CFG_IDX_W = 1;

  // Opcodes of input beats
  localparam logic [OP_W-1:0] OP_LOAD_LEN  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_CODE = 3'd1;
  localparam logic [OP_W-1:0] OP_START     = 3'd2;
  localparam logic [OP_W-1:0] OP_BIT       = 3'd3;
  localparam logic [OP_W-1:0] OP_END       = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] RES_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] RES_NO_MATCH = 2'd1;
  localparam logic [STATUS_W-1:0] RES_OVERRUN  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_MODE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_PRESENT = 1'b1;

  localparam logic [SYM_W-1:0] NIBBLE_MASK = 8'h0F;

  // Input beat payload, last field in the lowest bits
  typedef struct packed {
    logic [5:0]         pad;
    logic               stream_bit;
    logic [SYM_W-1:0]   symbol_value;
    logic [CODE_W-1:0]  code_value;
    logic [ENTRY_W-1:0] entry_index;
    logic [FIRST_W-1:0] first_index;
    logic [CNT_W-1:0]   length_count;
    logic [LSEL_W-1:0]  length_sel;
  } in_data_t;

  // Output beat payload, last field in the lowest bits
  typedef struct packed {
    logic [5:0]       pad;
    logic [NIB_W-1:0] val_y;
    logic [NIB_W-1:0] val_x;
    logic             val_w;
    logic             val_v;
    logic [SYM_W-1:0] raw_symbol;
  } out_data_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic                wr_len;
    logic                wr_code;
    logic                clr_code;
    logic                shift;
    logic                setup;
    logic                step;
    logic                set_result;
    logic                use_sym;
    logic [STATUS_W-1:0] res_status;
    logic                load_out;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic table_present;
    logic empty;
    logic at_max;
    logic hit;
    logic exhausted;
  } dp_stat_t;

endpackage

FILE: rtl/core/chpq_ctrl.sv
// Controller of the canonical Huffman pair/quad decoder: decode state machine
// and output beat valid. Depends on chpq_pkg; drives chpq_dp through dp_cmd_t.

module chpq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic [chpq_pkg::OP_W-1:0]   opcode_i,
  output logic                        s_tready_o,
  input  logic                        m_tready_i,
  output logic                        m_tvalid_o,
  input  chpq_pkg::dp_stat_t          stat_i,
  output chpq_pkg::dp_cmd_t           cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ARMED  = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       accept;
  logic       armed;

  assign s_tready_o = (state_q == S_IDLE) || (state_q == S_ARMED);
  assign accept     = s_tvalid_i && s_tready_o;
  assign armed      = (state_q == S_ARMED);
  assign m_tvalid_o = m_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE, S_ARMED: begin
        if (accept) begin
          case (opcode_i)
            chpq_pkg::OP_LOAD_LEN:  cmd_o.wr_len  = 1'b1;
            chpq_pkg::OP_LOAD_CODE: cmd_o.wr_code = 1'b1;
            chpq_pkg::OP_START: begin
              cmd_o.clr_code = 1'b1;
              if (!stat_i.table_present) begin
                cmd_o.set_result = 1'b1;
                cmd_o.res_status = chpq_pkg::RES_OK;
                state_d          = S_EMIT;
              end else begin
                state_d = S_ARMED;
              end
            end
            chpq_pkg::OP_BIT: begin
              if (armed) begin
                cmd_o.shift = 1'b1;
                state_d     = S_SETUP;
              end
            end
            chpq_pkg::OP_END: begin
              if (armed) begin
                cmd_o.set_result = 1'b1;
                cmd_o.res_status = chpq_pkg::RES_OVERRUN;
                state_d          = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        if (stat_i.empty) begin
          if (stat_i.at_max) begin
            cmd_o.set_result = 1'b1;
            cmd_o.res_status = chpq_pkg::RES_NO_MATCH;
            state_d          = S_EMIT;
          end else begin
            state_d = S_ARMED;
          end
        end else begin
          cmd_o.setup = 1'b1;
          state_d     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat_i.hit) begin
          cmd_o.set_result = 1'b1;
          cmd_o.use_sym    = 1'b1;
          cmd_o.res_status = chpq_pkg::RES_OK;
          state_d          = S_EMIT;
        end else if (stat_i.exhausted) begin
          if (stat_i.at_max) begin
            cmd_o.set_result = 1'b1;
            cmd_o.res_status = chpq_pkg::RES_NO_MATCH;
            state_d          = S_EMIT;
          end else begin
            state_d = S_ARMED;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_EMIT: begin
        // wait for the output register to drain
        if (!m_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

FILE: rtl/core/chpq_dp.sv
// Datapath of the canonical Huffman pair/quad decoder: configuration registers,
// code accumulator, per-length tables, sorted code memory, search and output.
// Depends on chpq_pkg; steered by chpq_ctrl.

module chpq_dp #(
  parameter int MAX_CODE_LEN  = chpq_pkg::MAX_CODE_LEN_DEF,
  parameter int TABLE_ENTRIES = chpq_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [chpq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic                              cfg_data_i,
  input  chpq_pkg::in_data_t                in_data_i,
  input  chpq_pkg::dp_cmd_t                 cmd_i,
  output chpq_pkg::dp_stat_t                stat_o,
  output chpq_pkg::out_data_t               out_data_o,
  output logic [chpq_pkg::STATUS_W-1:0]     out_status_o
);

  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int PW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = (PW > 10) ? PW : 10;
  localparam int CW = (MAX_CODE_LEN > chpq_pkg::CODE_W) ? MAX_CODE_LEN : chpq_pkg::CODE_W;

  // Configuration
  logic quad_mode_q;
  logic table_present_q;

  // Decode state
  logic [MAX_CODE_LEN-1:0] acc_q;
  logic [MAX_CODE_LEN:0]   acc_shift;
  logic [LW-1:0]           bits_q;

  // Per-length tables
  logic [chpq_pkg::CNT_W-1:0]   count_q [0:MAX_CODE_LEN];
  logic [chpq_pkg::FIRST_W-1:0] first_q [0:MAX_CODE_LEN];
  logic                         len_we;
  logic [LW-1:0]                len_idx;

  // Sorted code and symbol memory
  logic [chpq_pkg::CODE_W-1:0] code_mem [0:TABLE_ENTRIES-1];
  logic [chpq_pkg::SYM_W-1:0]  sym_mem  [0:TABLE_ENTRIES-1];
  logic [chpq_pkg::CODE_W-1:0] code_rd_q;
  logic [chpq_pkg::SYM_W-1:0]  sym_rd_q;
  logic                        ent_we;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;
  logic [SW-1:0]               rd_addr_full;

  // Search range
  logic [SW-1:0] lo_q, hi_q, mid_q;
  logic [SW-1:0] lo_c, hi_c, mid_c, sum_c;
  logic [SW-1:0] lo_n, hi_n, mid_n;
  logic [chpq_pkg::CNT_W-1:0]   cnt_c;
  logic [chpq_pkg::FIRST_W-1:0] fst_c;
  logic code_lt, code_eq;

  // Result held until the output register is free
  logic [chpq_pkg::STATUS_W-1:0] res_status_q;
  logic [chpq_pkg::SYM_W-1:0]    res_sym_q;
  logic [chpq_pkg::SYM_W-1:0]    hi_nib, lo_nib;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_mode_q     <= 1'b0;
      table_present_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        chpq_pkg::CFG_QUAD_MODE:     quad_mode_q     <= cfg_data_i;
        chpq_pkg::CFG_TABLE_PRESENT: table_present_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign acc_shift = {acc_q, in_data_i.stream_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      bits_q <= '0;
    end else if (cmd_i.clr_code) begin
      acc_q  <= '0;
      bits_q <= '0;
    end else if (cmd_i.shift) begin
      acc_q  <= acc_shift[MAX_CODE_LEN-1:0];
      bits_q <= bits_q + LW'(1);
    end
  end

  // Lengths of zero or beyond the maximum are dropped
  assign len_we  = cmd_i.wr_len && (in_data_i.length_sel != '0) &&
                   (32'(in_data_i.length_sel) <= MAX_CODE_LEN);
  assign len_idx = LW'(in_data_i.length_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= MAX_CODE_LEN; i++) begin
        count_q[i] <= '0;
      end
    end else if (len_we) begin
      count_q[len_idx] <= in_data_i.length_count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      first_q[len_idx] <= in_data_i.first_index;
    end
  end

  // Slice of the current length, cut at the end of the table
  assign cnt_c = count_q[bits_q];
  assign fst_c = first_q[bits_q];
  assign lo_c  = SW'(fst_c);
  assign sum_c = SW'(fst_c) + SW'(cnt_c);
  assign hi_c  = (sum_c > SW'(TABLE_ENTRIES)) ? SW'(TABLE_ENTRIES) : sum_c;
  assign mid_c = lo_c + ((hi_c - lo_c) >> 1);

  // One probe per cycle: compare the word read at mid, narrow the range
  assign code_lt = CW'(code_rd_q) < CW'(acc_q);
  assign code_eq = CW'(code_rd_q) == CW'(acc_q);
  assign lo_n    = code_lt ? (mid_q + SW'(1)) : lo_q;
  assign hi_n    = code_lt ? hi_q : mid_q;
  assign mid_n   = lo_n + ((hi_n - lo_n) >> 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      lo_q  <= lo_c;
      hi_q  <= hi_c;
      mid_q <= mid_c;
    end else if (cmd_i.step) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
    end
  end

  assign ent_we       = cmd_i.wr_code && (32'(in_data_i.entry_index) < TABLE_ENTRIES);
  assign wr_addr      = AW'(in_data_i.entry_index);
  assign rd_addr_full = cmd_i.setup ? mid_c : mid_n;
  assign rd_addr      = rd_addr_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      code_mem[wr_addr] <= in_data_i.code_value;
      sym_mem[wr_addr]  <= in_data_i.symbol_value;
    end
    code_rd_q <= code_mem[rd_addr];
    sym_rd_q  <= sym_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_result) begin
      res_status_q <= cmd_i.res_status;
      res_sym_q    <= cmd_i.use_sym ? sym_rd_q : '0;
    end
  end

  assign hi_nib = (res_sym_q >> 4) & chpq_pkg::NIBBLE_MASK;
  assign lo_nib = res_sym_q & chpq_pkg::NIBBLE_MASK;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_o          <= res_status_q;
      out_data_o.pad        <= '0;
      out_data_o.raw_symbol <= res_sym_q;
      if (quad_mode_q) begin
        out_data_o.val_v <= res_sym_q[3];
        out_data_o.val_w <= res_sym_q[2];
        out_data_o.val_x <= {{(chpq_pkg::NIB_W-1){1'b0}}, res_sym_q[1]};
        out_data_o.val_y <= {{(chpq_pkg::NIB_W-1){1'b0}}, res_sym_q[0]};
      end else begin
        out_data_o.val_v <= 1'b0;
        out_data_o.val_w <= 1'b0;
        out_data_o.val_x <= hi_nib[chpq_pkg::NIB_W-1:0];
        out_data_o.val_y <= lo_nib[chpq_pkg::NIB_W-1:0];
      end
    end
  end

  assign stat_o.table_present = table_present_q;
  assign stat_o.empty         = (cnt_c == '0) || (lo_c >= hi_c);
  assign stat_o.at_max        = (32'(bits_q) >= MAX_CODE_LEN);
  assign stat_o.hit           = code_eq;
  assign stat_o.exhausted     = (lo_n >= hi_n);

endmodule

FILE: rtl/core/canonical_huffman_pair_quad_decoder_unit.sv
// Channel   Direction  Handshake             Payload
// s_axis    in         s_tvalid_i/s_tready_o tuser opcode, tdata load/bit fields
// m_axis    out        m_tvalid_o/m_tready_i tuser status, tdata symbol and split
// cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Load beats give no result; a start beat with no table present and an end beat
// in the armed state give a result beat. A bit beat runs one memory read per
// binary search probe over the slice of the current length (up to 9 for a
// 256-entry slice) and may end in a result beat; the single read port of the sorted code memory sets this.
// Reset clears the length counts and the code and sets the configuration to pair mode with a table present.
// Input is held off while a search runs or a result waits for a full output.
// Top level; depends on chpq_pkg, chpq_ctrl and chpq_dp.

module canonical_huffman_pair_quad_decoder_unit #(
  parameter int MAX_CODE_LEN  = chpq_pkg::MAX_CODE_LEN_DEF,
  parameter int TABLE_ENTRIES = chpq_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // [4:0] length_sel, [13:5] length_count, [21:14] first_index, [29:22] entry_index,
  // [48:30] code_value, [56:49] symbol_value, [57] stream_bit
  input  logic [63:0]                       s_tdata_i,
  // [2:0] opcode
  input  logic [chpq_pkg::OP_W-1:0]         s_tuser_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // [7:0] raw_symbol, [8] val_v, [9] val_w, [13:10] val_x, [17:14] val_y
  output logic [23:0]                       m_tdata_o,
  // [1:0] status
  output logic [chpq_pkg::STATUS_W-1:0]     m_tuser_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [chpq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic                              cfg_data_i
);

  chpq_pkg::in_data_t  in_data;
  chpq_pkg::out_data_t out_data;
  chpq_pkg::dp_cmd_t   cmd;
  chpq_pkg::dp_stat_t  stat;

  assign in_data     = chpq_pkg::in_data_t'(s_tdata_i);
  assign m_tdata_o   = 24'(out_data);
  assign cfg_ready_o = 1'b1;

  chpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .opcode_i   (s_tuser_i),
    .s_tready_o (s_tready_o),
    .m_tready_i (m_tready_i),
    .m_tvalid_o (m_tvalid_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  chpq_dp #(
    .MAX_CODE_LEN  (MAX_CODE_LEN),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (in_data),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_data_o   (out_data),
    .out_status_o (m_tuser_o)
  );

endmodule
